[rtl/fnvfm_pkg.sv]
`timescale 1ns / 1ps
package fnvfm_pkg;

	localparam int unsigned HASH_W = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ADDR_W = 3;

	localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;
	localparam logic [HASH_W-1:0] FMIX_MUL1 = 32'h85EB_CA6B;
	localparam logic [HASH_W-1:0] FMIX_MUL2 = 32'hC2B2_AE35;

	// register word index, taken from paddr[2]
	localparam logic REG_SEED = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FMIX1 = 4'b0010,
		ST_FMIX2 = 4'b0100,
		ST_FINAL = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		SEL_ABSORB = 2'd0,
		SEL_SEED   = 2'd1,
		SEL_FMIX1  = 2'd2,
		SEL_FMIX2  = 2'd3
	} hash_sel_t;

	typedef struct packed {
		logic      load_hash;
		hash_sel_t sel;
		logic      use_seed;
		logic      load_out;
	} dp_cmd_t;

endpackage

[rtl/fnvfm_dp.sv]
`timescale 1ns / 1ps
module fnvfm_dp (
	input  logic                            clk,
	input  fnvfm_pkg::dp_cmd_t              cmd,
	input  logic [fnvfm_pkg::BYTE_W-1:0]    data_byte,
	input  logic [fnvfm_pkg::HASH_W-1:0]    seed_value,
	output logic [fnvfm_pkg::HASH_W-1:0]    hash_value
);
	import fnvfm_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] out_q;
	logic [HASH_W-1:0] base;
	logic [HASH_W-1:0] mul_a;
	logic [HASH_W-1:0] mul_k;
	logic [HASH_W-1:0] prod;
	logic [HASH_W-1:0] hash_next;

	assign base = cmd.use_seed ? seed_value : hash_q;

	// one shared multiplier, operand and constant picked per step
	always_comb begin
		mul_a     = hash_q;
		mul_k     = FNV_PRIME;
		hash_next = hash_q;
		case (cmd.sel)
			SEL_ABSORB: begin
				mul_a = base ^ {{(HASH_W-BYTE_W){1'b0}}, data_byte};
				mul_k = FNV_PRIME;
			end
			SEL_FMIX1: begin
				mul_a = hash_q ^ (hash_q >> 16);
				mul_k = FMIX_MUL1;
			end
			SEL_FMIX2: begin
				mul_a = hash_q ^ (hash_q >> 13);
				mul_k = FMIX_MUL2;
			end
			default: begin
				mul_a = hash_q;
				mul_k = FNV_PRIME;
			end
		endcase
		prod = mul_a * mul_k;
		if (cmd.sel == SEL_SEED) begin
			hash_next = seed_value;
		end else begin
			hash_next = prod;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hash) begin
			hash_q <= hash_next;
		end
		if (cmd.load_out) begin
			out_q <= hash_q ^ (hash_q >> 16);
		end
	end

	assign hash_value = out_q;

endmodule

[rtl/fnvfm_ctrl.sv]
`timescale 1ns / 1ps
module fnvfm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               last_byte,
	input  logic               empty_message,
	output logic               out_valid,
	input  logic               out_ready,
	output fnvfm_pkg::dp_cmd_t cmd
);
	import fnvfm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   in_msg_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		cmd.load_hash = 1'b0;
		cmd.sel       = SEL_ABSORB;
		cmd.use_seed  = !in_msg_q;
		cmd.load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load_hash = 1'b1;
					if (empty_message) begin
						cmd.sel = SEL_SEED;
						state_d = ST_FMIX1;
					end else if (last_byte) begin
						state_d = ST_FMIX1;
					end
				end
			end
			ST_FMIX1: begin
				cmd.load_hash = 1'b1;
				cmd.sel       = SEL_FMIX1;
				state_d       = ST_FMIX2;
			end
			ST_FMIX2: begin
				cmd.load_hash = 1'b1;
				cmd.sel       = SEL_FMIX2;
				state_d       = ST_FINAL;
			end
			ST_FINAL: begin
				// wait here while the previous result is still held
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				in_msg_q <= !empty_message && !last_byte;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken beat");

	a_end_starts_fmix: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (last_byte || empty_message)) |=> (state_q == ST_FMIX1 && !in_msg_q))
		else $error("final beat did not start finalizer");

	a_mid_byte_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !last_byte && !empty_message) |=> (state_q == ST_IDLE && in_msg_q))
		else $error("middle byte left idle or lost message flag");

	a_fmix_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FMIX1) |=> (state_q == ST_FMIX2))
		else $error("finalizer steps out of order");
`endif

endmodule

[rtl/fnv1a_32_hash_with_finalizer_core.sv]
`timescale 1ns / 1ps
// FNV-1a 32-bit hash with fmix32 finalizer, one message byte per beat. A byte
// that is not the last of its message is absorbed in the cycle it is taken, so
// such bytes stream at one per cycle. A last byte gets its FNV step as taken,
// an empty-message beat loads the seed; then the two fmix32 multiplies on one
// shared 32x32 multiplier and the final shift-xor into the output register
// run before the next beat is taken. The result sits in the output register,
// so the next message can start while a result waits; a second result waits
// in the final step until the first is taken. seed_value (byte address 0)
// resets to the FNV offset basis and is picked up at the start of each message.
module fnv1a_32_hash_with_finalizer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fnvfm_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [fnvfm_pkg::BYTE_W-1:0]    data_byte,
	input  logic                            last_byte,
	input  logic                            empty_message,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fnvfm_pkg::HASH_W-1:0]    hash_value
);
	import fnvfm_pkg::*;

	logic [HASH_W-1:0] seed_q;
	logic              cfg_wr;
	dp_cmd_t           cmd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);
	assign prdata = (paddr[2] == REG_SEED) ? seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= FNV_BASIS;
		end else if (cfg_wr) begin
			seed_q <= pwdata;
		end
	end

	fnvfm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.last_byte     (last_byte),
		.empty_message (empty_message),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cmd           (cmd)
	);

	fnvfm_dp u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.seed_value (seed_q),
		.hash_value (hash_value)
	);

endmodule
